// File: rtl/core/pbc_pkg.sv
// Shared constants, types and codes of the bounding circle block.
`default_nettype none

package pbc_pkg;

  // Storage depth default
  localparam int DEF_MAX_POINTS = 64;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int SCALE_W  = 16;
  localparam int CENTER_W = 20;
  localparam int RADIUS_W = 31;
  localparam int FRAC_W   = 8;

  // Distance arithmetic widths
  localparam int MAG_W    = COORD_W;
  localparam int PROD_W   = MAG_W + SCALE_W;
  localparam int SQ_W     = 2 * PROD_W;
  localparam int D2_W     = SQ_W + 1;
  localparam int RAD_IN_W = D2_W + (D2_W % 2);
  localparam int ROOT_W   = RAD_IN_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int STEP_W   = $clog2(ROOT_W + 1);
  localparam int MPROD_W  = COORD_W + SCALE_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  // 4.0 in Q.8 added to the root
  localparam logic [RADIUS_W-1:0] RADIUS_PAD = RADIUS_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X = 2'd0,
    REG_SCALE_Y = 2'd1
  } pbc_reg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } pbc_state_t;

  typedef struct packed {
    logic load;
    logic search_init;
    logic issue;
    logic root_start;
    logic out_load;
  } pbc_cmd_t;

  typedef struct packed {
    logic last_pair;
    logic pipe_busy;
    logic root_done;
    logic out_free;
  } pbc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pbc_ctrl.sv
// Controller state machine: sequences loading, pair search, root and output.
`default_nettype none

module pbc_ctrl import pbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        last_point,
  output logic             in_stall,
  output pbc_cmd_t         cmd,
  input  wire pbc_status_t status
);

  pbc_state_t state;
  pbc_state_t state_next;
  logic       accept;

  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && last_point) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.last_pair) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status.root_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state)
      ST_LOAD: begin
        cmd.load        = accept;
        cmd.search_init = accept && last_point;
      end
      ST_SEARCH: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.root_start = !status.pipe_busy;
      end
      ST_EMIT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/pbc_isqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none

module pbc_isqrt import pbc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [RAD_IN_W-1:0] radicand,
  output logic                     busy,
  output logic [ROOT_W-1:0]        root
);

  logic [RAD_IN_W-1:0] rad;
  logic [REM_W-1:0]    rem;
  logic [STEP_W-1:0]   steps;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // Bring in the next two radicand bits and test the trial divisor
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_IN_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Step count and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(ROOT_W);
    end else if (busy) begin
      busy  <= (steps != STEP_W'(1));
      steps <= steps - STEP_W'(1);
    end
  end

  // Remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_IN_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pbc_dp.sv
// Datapath: point store, pair distance pipeline, best pair, midpoint and output register.
`default_nettype none

module pbc_dp import pbc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [SCALE_W-1:0]         cfg_data,
  input  wire logic signed [COORD_W-1:0]  point_x,
  input  wire logic signed [COORD_W-1:0]  point_y,
  input  wire pbc_cmd_t                   cmd,
  output pbc_status_t                     status,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic signed [CENTER_W-1:0]      center_x,
  output logic signed [CENTER_W-1:0]      center_z,
  output logic [RADIUS_W-1:0]             radius,
  output logic                            overflowed
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int PW  = 2 * COORD_W;
  localparam int PPW = 2 * PW;

  logic [SCALE_W-1:0] scale_x;
  logic [SCALE_W-1:0] scale_y;

  logic [CW-1:0] point_count;
  logic          overflow_mark;
  logic          full;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] last_idx;

  logic [PW-1:0] store [MAX_POINTS];

  logic [AW-1:0] i_idx;
  logic [AW-1:0] j_idx;

  logic v1, v2, v3, v4;
  logic [PW-1:0]     rd_a;
  logic [PW-1:0]     rd_b;
  logic [PPW-1:0]    pair_s2;
  logic [PPW-1:0]    pair_s3;
  logic [PPW-1:0]    pair_s4;
  logic [PROD_W-1:0] ax;
  logic [PROD_W-1:0] ay;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic [D2_W-1:0]   d2;

  logic              have;
  logic [D2_W-1:0]   best_d2;
  logic [PPW-1:0]    best_pair;

  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  logic [COORD_W:0]        neg_x;
  logic [COORD_W:0]        neg_y;
  logic [MAG_W-1:0]        mag_x;
  logic [MAG_W-1:0]        mag_y;

  logic signed [COORD_W-1:0] bax, bay, bbx, bby;
  logic signed [COORD_W:0]   sum_x, sum_y, adj_x, adj_y;
  logic signed [COORD_W-1:0] mid_x, mid_y;
  logic signed [MPROD_W-1:0] mprod_x, mprod_y;
  logic signed [MPROD_W-1:0] cadj_x, cadj_y;

  logic                root_busy;
  logic [ROOT_W-1:0]   root;

  // Scale registers, written by configuration transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= SCALE_RESET;
      scale_y <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (pbc_reg_t'(cfg_index))
        REG_SCALE_X: scale_x <= cfg_data;
        REG_SCALE_Y: scale_y <= cfg_data;
        default: begin
          scale_x <= scale_x;
        end
      endcase
    end
  end

  assign full     = (point_count == CW'(MAX_POINTS));
  assign count_m1 = point_count - CW'(1);
  assign last_idx = count_m1[AW-1:0];

  // Point count and overflow mark; drop points once the store is full
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      overflow_mark <= 1'b0;
    end else if (cmd.out_load) begin
      point_count   <= '0;
      overflow_mark <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflow_mark <= 1'b1;
      end else begin
        point_count <= point_count + CW'(1);
      end
    end
  end

  // Point store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[point_count[AW-1:0]] <= {point_x, point_y};
    end
    rd_a <= store[i_idx];
    rd_b <= store[j_idx];
  end

  // Pair indices, j inner
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      i_idx <= '0;
      j_idx <= '0;
    end else if (cmd.issue) begin
      if (j_idx == last_idx) begin
        j_idx <= '0;
        i_idx <= i_idx + AW'(1);
      end else begin
        j_idx <= j_idx + AW'(1);
      end
    end
  end

  // Valid bits of the distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Absolute coordinate differences
  always_comb begin
    diff_x = {rd_b[PW-1], rd_b[PW-1 -: COORD_W]} - {rd_a[PW-1], rd_a[PW-1 -: COORD_W]};
    diff_y = {rd_b[COORD_W-1], rd_b[COORD_W-1:0]} - {rd_a[COORD_W-1], rd_a[COORD_W-1:0]};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    mag_x  = diff_x[COORD_W] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
    mag_y  = diff_y[COORD_W] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
  end

  // Scale, square, sum
  always_ff @(posedge clk) begin
    ax      <= PROD_W'(mag_x) * PROD_W'(scale_x);
    ay      <= PROD_W'(mag_y) * PROD_W'(scale_y);
    pair_s2 <= {rd_a, rd_b};
    sqx     <= SQ_W'(ax) * SQ_W'(ax);
    sqy     <= SQ_W'(ay) * SQ_W'(ay);
    pair_s3 <= pair_s2;
    d2      <= D2_W'(sqx) + D2_W'(sqy);
    pair_s4 <= pair_s3;
  end

  // Keep the first pair with strictly greatest distance
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.search_init) begin
      have <= 1'b0;
    end else if (v4) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && (!have || (d2 > best_d2))) begin
      best_d2   <= d2;
      best_pair <= pair_s4;
    end
  end

  // Midpoint, halved toward zero, then scaled; runs freely off the best pair
  always_comb begin
    bax   = best_pair[PPW-1 -: COORD_W];
    bay   = best_pair[PPW-COORD_W-1 -: COORD_W];
    bbx   = best_pair[PW-1 -: COORD_W];
    bby   = best_pair[COORD_W-1:0];
    sum_x = {bax[COORD_W-1], bax} + {bbx[COORD_W-1], bbx};
    sum_y = {bay[COORD_W-1], bay} + {bby[COORD_W-1], bby};
    adj_x = sum_x + {{COORD_W{1'b0}}, sum_x[COORD_W] & sum_x[0]};
    adj_y = sum_y + {{COORD_W{1'b0}}, sum_y[COORD_W] & sum_y[0]};
  end

  always_ff @(posedge clk) begin
    mid_x   <= adj_x[COORD_W:1];
    mid_y   <= adj_y[COORD_W:1];
    mprod_x <= MPROD_W'(mid_x) * MPROD_W'($signed({1'b0, scale_x}));
    mprod_y <= MPROD_W'(mid_y) * MPROD_W'($signed({1'b0, scale_y}));
  end

  // Drop the fraction toward zero
  always_comb begin
    cadj_x = mprod_x + (mprod_x[MPROD_W-1] ? MPROD_W'({FRAC_W{1'b1}}) : '0);
    cadj_y = mprod_y + (mprod_y[MPROD_W-1] ? MPROD_W'({FRAC_W{1'b1}}) : '0);
  end

  pbc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (RAD_IN_W'(best_d2)),
    .busy     (root_busy),
    .root     (root)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      center_x   <= cadj_x[FRAC_W+CENTER_W-1:FRAC_W];
      center_z   <= cadj_y[FRAC_W+CENTER_W-1:FRAC_W];
      radius     <= RADIUS_W'(root) + RADIUS_PAD;
      overflowed <= overflow_mark;
    end
  end

  // Status to the controller
  always_comb begin
    status.last_pair = (i_idx == last_idx) && (j_idx == last_idx);
    status.pipe_busy = v1 || v2 || v3 || v4;
    status.root_done = !root_busy;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// File: rtl/core/point_set_bounding_circle_top.sv
// Top level of the point set bounding circle block.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_stall    point_x, point_y, last_point
//   out      out        out_valid/out_stall  center_x, center_z, radius, overflowed
//
// Each point is stored as it is taken. The closing point starts the pair
// search (one ordered pair per cycle through the two store read ports), then
// the distance pipeline drains, then the square root runs (29 result bits at
// one per cycle), then the result is loaded into the output register once
// that register is free.
// Reset is synchronous and clears control state and the scales to 1.0.
// Input is stalled from the closing point until the result is loaded into the
// output register; a result stalled there holds without blocking the next set.
`default_nettype none

module point_set_bounding_circle_top import pbc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [SCALE_W-1:0]         cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [COORD_W-1:0]  point_x,
  input  wire logic signed [COORD_W-1:0]  point_y,
  input  wire logic                       last_point,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [CENTER_W-1:0]      center_x,
  output logic signed [CENTER_W-1:0]      center_z,
  output logic [RADIUS_W-1:0]             radius,
  output logic                            overflowed
);

  pbc_cmd_t    cmd;
  pbc_status_t status;

  // Configuration transactions are always taken
  assign cfg_ready = 1'b1;

  pbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_point (last_point),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .status     (status)
  );

  pbc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_x    (point_x),
    .point_y    (point_y),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .center_x   (center_x),
    .center_z   (center_z),
    .radius     (radius),
    .overflowed (overflowed)
  );

endmodule

`default_nettype wire

// File: rtl/core/pbc_chk.sv
// Port-level checker for the bounding circle block, bound to the top level.
`default_nettype none

module pbc_chk import pbc_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       last_point,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [CENTER_W-1:0] center_x,
  input wire logic signed [CENTER_W-1:0] center_z,
  input wire logic [RADIUS_W-1:0]        radius,
  input wire logic                       overflowed
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(center_x) && $stable(center_z)
      && $stable(radius) && $stable(overflowed))
    else $error("stalled result changed");

  // Keep loading after a point that does not close the set
  a_keep_loading: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_point |=> !in_stall)
    else $error("input stalled in the middle of a set");

  // Stall input once the closing point is taken
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_point |=> in_stall)
    else $error("input taken during the pair search");

  // A new result appears only at the end of a search
  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while loading");

  // Radius always carries the 4.0 pad
  a_radius_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> radius >= RADIUS_PAD)
    else $error("radius below pad");

endmodule

bind point_set_bounding_circle_top pbc_chk u_pbc_chk (.*);

`default_nettype wire

// File: tb/bounding_circle_checker.sv
// Checker that predicts each bounding circle of a point set and compares it with the block.
`timescale 1ns / 100ps

module bounding_circle_checker import pbc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SCALE_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      last_point,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [CENTER_W-1:0] center_x,
  input  logic signed [CENTER_W-1:0] center_z,
  input  logic [RADIUS_W-1:0]       radius,
  input  logic                      overflowed,
  output int                        circles_open,
  output int                        field_errors
);

  typedef struct packed {
    logic signed [CENTER_W-1:0] mid_x;
    logic signed [CENTER_W-1:0] mid_y;
    logic [RADIUS_W-1:0]        rad;
    logic                       ovf;
  } circle_t;

  // Shadow copy of the scales and the point store
  logic [SCALE_W-1:0]        scale_x = SCALE_RESET;
  logic [SCALE_W-1:0]        scale_y = SCALE_RESET;
  logic signed [COORD_W-1:0] pts_x [MAX_POINTS];
  logic signed [COORD_W-1:0] pts_y [MAX_POINTS];
  int                        n_pts;
  bit                        dropped;
  circle_t                   awaited_circles[$];
  int                        errs;

  // Squared scaled distance between two stored points, Q.16
  function automatic longint pair_span2(int a, int b);
    longint dx, dy;
    dx = (longint'(pts_x[b]) - longint'(pts_x[a])) * longint'(scale_x);
    dy = (longint'(pts_y[b]) - longint'(pts_y[a])) * longint'(scale_y);
    return dx * dx + dy * dy;
  endfunction

  // Largest r with r*r <= v, one bit at a time from the top
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Midpoint truncated toward zero, then scaled and truncated toward zero
  function automatic logic signed [CENTER_W-1:0] scaled_mid(
    logic signed [COORD_W-1:0] p, logic signed [COORD_W-1:0] q, logic [SCALE_W-1:0] s);
    int     m;
    longint c;
    m = (int'(p) + int'(q)) / 2;
    c = (longint'(m) * longint'(s)) / 256;
    return c[CENTER_W-1:0];
  endfunction

  // Search every ordered pair, keep the first strictly farthest one
  function automatic circle_t farthest_pair_circle();
    longint          best, d;
    int              a, b;
    longint unsigned rr;
    circle_t         c;
    best = 0;
    a = 0;
    b = 0;
    for (int i = 0; i < n_pts; i++) begin
      for (int j = 0; j < n_pts; j++) begin
        d = pair_span2(i, j);
        if (d > best) begin
          best = d;
          a = i;
          b = j;
        end
      end
    end
    rr = root_floor(longint'(best)) + 1024;
    c.mid_x = scaled_mid(pts_x[a], pts_x[b], scale_x);
    c.mid_y = scaled_mid(pts_y[a], pts_y[b], scale_y);
    c.rad   = rr[RADIUS_W-1:0];
    c.ovf   = dropped;
    return c;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      if (errs < 10)
        $display("%t: %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    circle_t want;
    if (rst) begin
      scale_x = SCALE_RESET;
      scale_y = SCALE_RESET;
      n_pts   = 0;
      dropped = 1'b0;
      awaited_circles.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_X: scale_x = cfg_data;
          REG_SCALE_Y: scale_y = cfg_data;
          default: ;
        endcase
      end

      // Compare an outgoing circle with the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_circles.size() == 0) begin
          if (errs < 10)
            $display("%t: circle with none pending: x %0d z %0d radius %0d overflow %0b",
                     $realtime, center_x, center_z, radius, overflowed);
          errs++;
        end else begin
          want = awaited_circles.pop_front();
          check_field("center_x", longint'(want.mid_x), longint'(center_x));
          check_field("center_z", longint'(want.mid_y), longint'(center_z));
          check_field("radius", longint'(want.rad), longint'(radius));
          check_field("overflowed", longint'(want.ovf), longint'(overflowed));
        end
      end

      // Store an incoming point, drop it when full, close the set on the last one
      if (in_valid && !in_stall) begin
        if (n_pts < MAX_POINTS) begin
          pts_x[n_pts] = point_x;
          pts_y[n_pts] = point_y;
          n_pts++;
        end else begin
          dropped = 1'b1;
        end
        if (last_point) begin
          awaited_circles.push_back(farthest_pair_circle());
          n_pts   = 0;
          dropped = 1'b0;
        end
      end
    end
    circles_open <= awaited_circles.size();
    field_errors <= errs;
  end

endmodule

// File: tb/point_set_bounding_circle_top_test.sv
// Stimulus, clock, reset and verdict for the point set bounding circle block.
`timescale 1ns / 100ps

module point_set_bounding_circle_top_test;
  import pbc_pkg::*;

  localparam int MAX_POINTS      = DEF_MAX_POINTS;
  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 64;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int CYCLE_LIMIT     = 2000000;

  // Indexes outside the register list, written to check that they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_CLUSTER,
    SPREAD_EDGE
  } spread_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [SCALE_W-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic                       last_point;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_z;
  logic [RADIUS_W-1:0]        radius;
  logic                       overflowed;

  int circles_open;
  int field_errors;
  int cycle_count = 0;
  int in_quiet = 0;
  int out_quiet = 0;

  point_set_bounding_circle_top #(
    .MAX_POINTS(MAX_POINTS)
  ) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_x(center_x), .center_z(center_z), .radius(radius), .overflowed(overflowed)
  );

  bounding_circle_checker #(
    .MAX_POINTS(MAX_POINTS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_x(center_x), .center_z(center_z), .radius(radius), .overflowed(overflowed),
    .circles_open(circles_open), .field_errors(field_errors)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Random wait before each transaction, with occasional stretches of no waiting
  function automatic int pick_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(8, 40);
    return $urandom_range(0, 17);
  endfunction

  function automatic int pick_coord(spread_t spread);
    case (spread)
      SPREAD_CLUSTER: return int'($urandom_range(0, 6)) - 3;
      SPREAD_EDGE: begin
        case ($urandom_range(0, 5))
          0: return -2048;
          1: return -2047;
          2: return -1;
          3: return 0;
          4: return 2046;
          default: return 2047;
        endcase
      end
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // Result side: stall each circle for a drawn number of cycles
  initial begin : receive
    int hold;
    out_stall = 1'b0;
    hold = pick_wait(out_quiet);
    forever begin
      @(posedge clk);
      if (!rst && out_valid) begin
        if (!out_stall) hold = pick_wait(out_quiet);
        else if (hold > 0) hold--;
      end
      @(negedge clk);
      out_stall <= (hold > 0);
    end
  end

  // Present one point and hold it until the transaction completes
  task automatic drive_point(input int x, input int y, input bit closing);
    int gap;
    gap = pick_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    point_x    <= COORD_W'(x);
    point_y    <= COORD_W'(y);
    last_point <= closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy,
                            input bit with_spare);
    if (with_spare) begin
      write_reg(REG_SPARE_A, SCALE_W'($urandom));
      write_reg(REG_SPARE_B, SCALE_W'($urandom));
    end
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    cfg_valid <= 1'b0;
  endtask

  // Drain all pending circles, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (circles_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly small sets, a few large ones up to a full store, a few that overflow the store
  task automatic send_random_set(output int sent);
    int      count, pick;
    spread_t spread;
    pick = $urandom_range(0, 99);
    if (pick < 60) count = $urandom_range(1, 6);
    else if (pick < 85) count = $urandom_range(7, 20);
    else if (pick < 93) count = $urandom_range(60, MAX_POINTS);
    else count = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 6);
    spread = spread_t'($urandom_range(0, 2));
    for (int k = 0; k < count; k++)
      drive_point(pick_coord(spread), pick_coord(spread), k == count - 1);
    sent = count;
  endtask

  initial begin : stimulus
    int                 sent, in_phase;
    logic [SCALE_W-1:0] sx, sy;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SCALE_X;
    cfg_data   = '0;
    in_valid   = 1'b0;
    point_x    = '0;
    point_y    = '0;
    last_point = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single point at a corner of the coordinate range
    drive_point(-2048, 2047, 1'b1);
    // Full diagonal span
    drive_point(-2048, -2048, 1'b0);
    drive_point(2047, 2047, 1'b1);
    // Opposite diagonal with a point at the origin
    drive_point(2047, -2048, 1'b0);
    drive_point(-2048, 2047, 1'b0);
    drive_point(0, 0, 1'b1);
    // Square: equal distances, first farthest pair wins
    drive_point(1, 1, 1'b0);
    drive_point(-1, -1, 1'b0);
    drive_point(-1, 1, 1'b0);
    drive_point(1, -1, 1'b1);
    // Odd negative sums truncate toward zero
    drive_point(-3, -1, 1'b0);
    drive_point(0, 0, 1'b1);
    // Duplicate points give the bare pad
    drive_point(5, 5, 1'b0);
    drive_point(5, 5, 1'b1);
    // Equal spans on both axes
    drive_point(2047, 0, 1'b0);
    drive_point(-2048, 0, 1'b0);
    drive_point(0, 2047, 1'b0);
    drive_point(0, -2048, 1'b1);

    // Random sets under a sweep of scale settings
    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_idle();
      case (phase)
        1: begin sx = 16'd1;     sy = 16'd1;     end
        2: begin sx = 16'd65535; sy = 16'd65535; end
        3: begin sx = 16'd65535; sy = 16'd1;     end
        4: begin sx = 16'd1;     sy = 16'd65535; end
        5: begin sx = 16'd0;     sy = SCALE_W'($urandom_range(1, 65535)); end
        6: begin sx = SCALE_W'($urandom_range(1, 65535)); sy = 16'd0; end
        default: begin
          sx = SCALE_W'($urandom_range(1, 65535));
          sy = SCALE_W'($urandom_range(1, 65535));
        end
      endcase
      set_scales(sx, sy, phase >= 5);
      in_phase = 0;
      while (in_phase < ITEMS_PER_PHASE) begin
        send_random_set(sent);
        in_phase += sent;
      end
    end

    wait_idle();
    if (field_errors == 0 && circles_open == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
